/* sv/first_fit_extent_allocator_macros.svh */
// Assertion macros for the first-fit extent allocator checker.
// Every macro expects signals named clk and rst in the scope where it is used.
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define FAE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define FAE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/fae_pkg.sv */
// Shared constants for the first-fit extent allocator: field widths,
// request kinds, status codes and parameter defaults. No dependencies.
package fae_pkg;

  localparam int FAE_MEM_SIZE    = 1024;
  localparam int FAE_MAX_EXTENTS = 16;

  localparam int KIND_W      = 2;
  localparam int SIZE_W      = 11;
  localparam int ADDR_W      = 10;
  localparam int STATUS_W    = 2;
  localparam int S_TDATA_W   = 24;
  localparam int M_TDATA_W   = 16;

  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COMPACT = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd3;

endpackage

/* sv/first_fit_extent_allocator.sv */
// First-fit extent allocator: address-ordered free extent table in a
// small memory, walked by a sequencer around one shared adder.
// Depends on fae_pkg.
//
//  channel | dir | signals                         | carries
//  --------+-----+---------------------------------+-------------------------------
//  s_      | in  | s_tvalid s_tready s_tdata s_tuser | request: kind, size, addr
//  m_      | out | m_tvalid m_tready m_tdata       | result: granted, alloc_addr, status
//
// One request at a time; each table entry visited takes a registered read, then a compare.
// Rejects go straight to the result; allocate scans, then moves later entries down if an
// extent is used up; release scans, then moves entries up; compact of two or more extents
// compares neighbours and moves later entries down on each merge.
// After reset the S_INIT state writes the initial extent; s_tready stays low for it.
// A result held on m_ while m_tready is low stalls only the next finish.
module first_fit_extent_allocator
  import fae_pkg::*;
#(
  parameter int MEM_SIZE    = FAE_MEM_SIZE,
  parameter int MAX_EXTENTS = FAE_MAX_EXTENTS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [10:0] size, [20:11] addr, zero fill
  input  logic [KIND_W-1:0]    s_tuser,   // [1:0] kind
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata    // [0] granted, [10:1] alloc_addr, [12:11] status
);

  localparam int AW = $clog2(MEM_SIZE);
  localparam int SW = ((AW > SIZE_W) ? AW : SIZE_W) + 1;
  localparam int IW = $clog2(MAX_EXTENTS);
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam logic [SW-1:0] MEM_SIZE_W = SW'(MEM_SIZE);
  localparam logic [AW-1:0] LAST_ADDR  = AW'(MEM_SIZE - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_EXTENTS);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DEC,
    S_AL_RD, S_AL_EV,
    S_RM_RD, S_RM_WR,
    S_RL_LAST, S_RL_RD, S_RL_EV, S_SH_RD, S_SH_WR,
    S_CP_RD0, S_CP_LD, S_CP_RD, S_CP_EV,
    S_DONE
  } state_t;

  state_t state;

  // table memory
  logic [AW-1:0] start_mem [MAX_EXTENTS];
  logic [AW-1:0] end_mem   [MAX_EXTENTS];
  logic [AW-1:0] rd_start, rd_end;
  logic [IW-1:0] raddr, waddr;
  logic          we_start, we_end;
  logic [AW-1:0] wdata_start, wdata_end;

  // request and working registers
  logic [KIND_W-1:0]   req_kind;
  logic [SIZE_W-1:0]   req_size;
  logic [ADDR_W-1:0]   req_addr;
  logic [CW-1:0]       count;
  logic [CW-1:0]       scan;
  logic [CW-1:0]       mv;
  logic [AW-1:0]       last;
  logic [AW-1:0]       prev_end;
  logic                res_granted;
  logic [ADDR_W-1:0]   res_addr;
  logic [STATUS_W-1:0] res_status;
  logic                out_granted;
  logic [ADDR_W-1:0]   out_addr;
  logic [STATUS_W-1:0] out_status;

  // shared adder
  logic [SW-1:0] alu_a, alu_b, alu_sum, end_p1;
  logic          fit, exact, merge;
  logic [AW-1:0] last_next;

  assign alu_sum   = alu_a + alu_b;
  assign end_p1    = SW'(rd_end) + SW'(1);
  assign fit       = (alu_sum <= end_p1);
  assign exact     = (alu_sum == end_p1);
  assign merge     = (alu_sum == SW'(rd_start));
  assign last_next = (alu_sum > MEM_SIZE_W) ? LAST_ADDR : AW'(alu_sum - SW'(1));

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {3'b000, out_status, out_addr, out_granted};

  always_comb begin
    raddr       = '0;
    waddr       = '0;
    we_start    = 1'b0;
    we_end      = 1'b0;
    wdata_start = rd_start;
    wdata_end   = rd_end;
    alu_a       = '0;
    alu_b       = '0;
    case (state)
      S_INIT: begin
        we_start    = 1'b1;
        we_end      = 1'b1;
        wdata_start = '0;
        wdata_end   = LAST_ADDR;
      end
      S_AL_RD: raddr = scan[IW-1:0];
      S_AL_EV: begin
        alu_a = SW'(rd_start);
        alu_b = SW'(req_size);
        if (fit && !exact) begin
          we_start    = 1'b1;
          waddr       = scan[IW-1:0];
          wdata_start = AW'(alu_sum);
        end
      end
      S_RM_RD: raddr = IW'(mv + 1'b1);
      S_RM_WR: begin
        we_start = 1'b1;
        we_end   = 1'b1;
        waddr    = mv[IW-1:0];
      end
      S_RL_LAST: begin
        alu_a = SW'(req_addr);
        alu_b = SW'(req_size);
      end
      S_RL_RD: raddr = scan[IW-1:0];
      S_SH_RD: begin
        if (mv == scan) begin
          we_start    = 1'b1;
          we_end      = 1'b1;
          waddr       = scan[IW-1:0];
          wdata_start = AW'(req_addr);
          wdata_end   = last;
        end else begin
          raddr = IW'(mv - 1'b1);
        end
      end
      S_SH_WR: begin
        we_start = 1'b1;
        we_end   = 1'b1;
        waddr    = mv[IW-1:0];
      end
      S_CP_RD0: raddr = '0;
      S_CP_RD:  raddr = scan[IW-1:0];
      S_CP_EV: begin
        alu_a = SW'(prev_end);
        alu_b = SW'(1);
        if (merge) begin
          we_end    = 1'b1;
          waddr     = IW'(scan - 1'b1);
          wdata_end = rd_end;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_start) start_mem[waddr] <= wdata_start;
    if (we_end) end_mem[waddr] <= wdata_end;
    rd_start <= start_mem[raddr];
    rd_end   <= end_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      count    <= CW'(1);
      m_tvalid <= 1'b0;
    end else begin
      // S_DONE reloads the result itself
      if (m_tvalid && m_tready && state != S_DONE) m_tvalid <= 1'b0;
      case (state)
        S_INIT: state <= S_IDLE;
        S_IDLE: begin
          if (s_tvalid) begin
            req_kind <= s_tuser;
            req_size <= s_tdata[SIZE_W-1:0];
            req_addr <= s_tdata[SIZE_W+ADDR_W-1:SIZE_W];
            state    <= S_DEC;
          end
        end
        S_DEC: begin
          res_granted <= 1'b0;
          res_addr    <= '0;
          res_status  <= ST_OK;
          scan        <= '0;
          case (req_kind)
            KIND_ALLOC: begin
              if (req_size == '0) begin
                res_status <= ST_ZERO;
                state      <= S_DONE;
              end else if (count == '0) begin
                res_status <= ST_NOFIT;
                state      <= S_DONE;
              end else begin
                state <= S_AL_RD;
              end
            end
            KIND_RELEASE: begin
              if (req_size == '0) begin
                res_status <= ST_ZERO;
                state      <= S_DONE;
              end else if (SW'(req_addr) >= MEM_SIZE_W) begin
                res_status <= ST_NOFIT;
                state      <= S_DONE;
              end else if (count == FULL_COUNT) begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end else begin
                state <= S_RL_LAST;
              end
            end
            KIND_COMPACT: begin
              res_granted <= 1'b1;
              state       <= (count < CW'(2)) ? S_DONE : S_CP_RD0;
            end
            default: state <= S_DONE;
          endcase
        end
        S_AL_RD: state <= S_AL_EV;
        S_AL_EV: begin
          if (fit) begin
            res_granted <= 1'b1;
            res_addr    <= ADDR_W'(rd_start);
            if (exact) begin
              mv    <= scan;
              state <= S_RM_RD;
            end else begin
              state <= S_DONE;
            end
          end else if (scan + 1'b1 == count) begin
            res_status <= ST_NOFIT;
            state      <= S_DONE;
          end else begin
            scan  <= scan + 1'b1;
            state <= S_AL_RD;
          end
        end
        // close the gap at mv by moving later entries down
        S_RM_RD: begin
          if (mv + 1'b1 >= count) begin
            count <= count - 1'b1;
            state <= (req_kind == KIND_COMPACT) ? S_CP_RD : S_DONE;
          end else begin
            state <= S_RM_WR;
          end
        end
        S_RM_WR: begin
          mv    <= mv + 1'b1;
          state <= S_RM_RD;
        end
        S_RL_LAST: begin
          last  <= last_next;
          state <= S_RL_RD;
        end
        S_RL_RD: begin
          if (scan >= count) begin
            mv    <= count;
            state <= S_SH_RD;
          end else begin
            state <= S_RL_EV;
          end
        end
        S_RL_EV: begin
          if (SW'(rd_start) < SW'(req_addr)) begin
            scan  <= scan + 1'b1;
            state <= S_RL_RD;
          end else begin
            mv    <= count;
            state <= S_SH_RD;
          end
        end
        // open a slot at scan by moving entries up, top first
        S_SH_RD: begin
          if (mv == scan) begin
            count       <= count + 1'b1;
            res_granted <= 1'b1;
            state       <= S_DONE;
          end else begin
            state <= S_SH_WR;
          end
        end
        S_SH_WR: begin
          mv    <= mv - 1'b1;
          state <= S_SH_RD;
        end
        S_CP_RD0: state <= S_CP_LD;
        S_CP_LD: begin
          prev_end <= rd_end;
          scan     <= CW'(1);
          state    <= S_CP_RD;
        end
        S_CP_RD: state <= (scan >= count) ? S_DONE : S_CP_EV;
        S_CP_EV: begin
          prev_end <= rd_end;
          if (merge) begin
            mv    <= scan;
            state <= S_RM_RD;
          end else begin
            scan  <= scan + 1'b1;
            state <= S_CP_RD;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid    <= 1'b1;
            out_granted <= res_granted;
            out_addr    <= res_addr;
            out_status  <= res_status;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/fae_checker.sv */
// Port-level checks for the first-fit extent allocator, bound into first_fit_extent_allocator.
// Depends on fae_pkg and first_fit_extent_allocator_macros.svh.
`include "first_fit_extent_allocator_macros.svh"

module fae_checker
  import fae_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata
);

  `FAE_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // one request in flight: never ready right after taking one
  `FAE_ASSERT_NXT(a_busy_after_req, s_tvalid && s_tready, !s_tready, "ready again right after a request")

  `FAE_ASSERT_IMP(a_grant_ok, m_tvalid && m_tdata[0], m_tdata[12:11] == ST_OK, "granted with error status")

  `FAE_ASSERT_IMP(a_addr_zero, m_tvalid && !m_tdata[0], m_tdata[10:1] == '0, "address on a refused request")

  // initial extent is written in the first cycle out of reset
  `FAE_ASSERT_IMP(a_init_cycle, $fell(rst), !s_tready && !m_tvalid, "active in the init cycle")

endmodule

bind first_fit_extent_allocator fae_checker u_fae_checker (.*);

/* tb/testbench.sv */
// Self-checking testbench for first_fit_extent_allocator: directed table, then random
// allocate/release/compact/unused-kind traffic scored against a free-extent table predictor.
// Depends on fae_pkg and the allocator RTL.
module testbench;
  import fae_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS = 850;
  localparam int SETTLE_CYCLES   = 100;
  localparam int PAD_W           = S_TDATA_W - ADDR_W - SIZE_W;

  typedef struct packed {
    logic                granted;
    logic [ADDR_W-1:0]   alloc_addr;
    logic [STATUS_W-1:0] status;
  } grant_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    int                size;
    int                addr;
    int                reps;
    int                step;
    bit                typed;
    grant_t            want;
  } plan_row_t;

  typedef struct {
    int addr;
    int size;
  } block_t;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic [KIND_W-1:0]    s_tuser  = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  // free extent table mirror
  logic [ADDR_W-1:0] free_lo [FAE_MAX_EXTENTS];
  logic [ADDR_W-1:0] free_hi [FAE_MAX_EXTENTS];
  int                free_cnt;

  grant_t pending_grants [$];
  block_t held_blocks [$];
  int     mismatches = 0;
  bit     calm       = 1'b0;

  // kind, size, addr, repeat, addr step, typed, expected {granted, alloc_addr, status}
  plan_row_t directed_plan [25] = '{
    '{KIND_ALLOC,      0,    0,  1, 0, 1'b1, '{1'b0, 10'd0, ST_ZERO}},
    '{KIND_RELEASE,    0, 1023,  1, 0, 1'b1, '{1'b0, 10'd0, ST_ZERO}},
    '{KIND_UNUSED,  1024, 1023,  1, 0, 1'b1, '{1'b0, 10'd0, ST_OK}},
    '{KIND_COMPACT,    0,    0,  1, 0, 1'b1, '{1'b1, 10'd0, ST_OK}},
    '{KIND_ALLOC,      1,    0,  1, 0, 1'b1, '{1'b1, 10'd0, ST_OK}},
    '{KIND_ALLOC,   1024,    0,  1, 0, 1'b1, '{1'b0, 10'd0, ST_NOFIT}},
    '{KIND_ALLOC,   1023,    0,  1, 0, 1'b1, '{1'b1, 10'd1, ST_OK}},
    '{KIND_ALLOC,      1,    0,  1, 0, 1'b1, '{1'b0, 10'd0, ST_NOFIT}},
    '{KIND_COMPACT,    0,    0,  1, 0, 1'b1, '{1'b1, 10'd0, ST_OK}},
    '{KIND_RELEASE, 1024, 1023,  1, 0, 1'b1, '{1'b1, 10'd0, ST_OK}},
    '{KIND_RELEASE,    1,    0,  1, 0, 1'b1, '{1'b1, 10'd0, ST_OK}},
    '{KIND_RELEASE, 1022,    1,  1, 0, 1'b1, '{1'b1, 10'd0, ST_OK}},
    '{KIND_COMPACT,    0,    0,  1, 0, 1'b1, '{1'b1, 10'd0, ST_OK}},
    '{KIND_ALLOC,   1024,    0,  1, 0, 1'b1, '{1'b1, 10'd0, ST_OK}},
    '{KIND_RELEASE,    1,    0, 16, 2, 1'b1, '{1'b1, 10'd0, ST_OK}},
    '{KIND_RELEASE,    5,  100,  1, 0, 1'b1, '{1'b0, 10'd0, ST_FULL}},
    '{KIND_COMPACT,    0,    0,  1, 0, 1'b1, '{1'b1, 10'd0, ST_OK}},
    '{KIND_ALLOC,      2,    0,  1, 0, 1'b1, '{1'b0, 10'd0, ST_NOFIT}},
    '{KIND_ALLOC,      1,    0,  5, 0, 1'b0, '{1'b0, 10'd0, ST_OK}},
    '{KIND_RELEASE,   20,   10,  1, 0, 1'b0, '{1'b0, 10'd0, ST_OK}},
    '{KIND_RELEASE,   20,    5,  1, 0, 1'b0, '{1'b0, 10'd0, ST_OK}},
    '{KIND_RELEASE,   10,   30,  1, 0, 1'b0, '{1'b0, 10'd0, ST_OK}},
    '{KIND_COMPACT,    0,    0,  1, 0, 1'b0, '{1'b0, 10'd0, ST_OK}},
    '{KIND_ALLOC,     30,    0,  1, 0, 1'b0, '{1'b0, 10'd0, ST_OK}},
    '{KIND_ALLOC,    682,    0,  1, 0, 1'b0, '{1'b0, 10'd0, ST_OK}}
  };

  first_fit_extent_allocator DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    for (int i = 0; i < FAE_MAX_EXTENTS; i++) begin
      free_lo[i] = '0;
      free_hi[i] = '0;
    end
    free_hi[0] = ADDR_W'(FAE_MEM_SIZE - 1);
    free_cnt   = 1;
  end

  function automatic void drop_extent(int pos);
    for (int i = pos; i + 1 < free_cnt; i++) begin
      free_lo[i] = free_lo[i + 1];
      free_hi[i] = free_hi[i + 1];
    end
    free_cnt--;
  endfunction

  function automatic grant_t predict_grant(logic [KIND_W-1:0] kind, int size, int addr);
    grant_t g;
    int     len;
    int     last;
    int     pos;
    int     i;
    bit     found;
    g = '0;
    case (kind)
      KIND_ALLOC: begin
        if (size == 0) begin
          g.status = ST_ZERO;
        end else begin
          g.status = ST_NOFIT;
          found = 1'b0;
          for (i = 0; i < free_cnt && !found; i++) begin
            len = int'(free_hi[i]) - int'(free_lo[i]) + 1;
            if (free_hi[i] >= free_lo[i] && len >= size) begin
              found        = 1'b1;
              g.granted    = 1'b1;
              g.alloc_addr = free_lo[i];
              g.status     = ST_OK;
              if (len > size) free_lo[i] = ADDR_W'(int'(free_lo[i]) + size);
              else drop_extent(i);
            end
          end
        end
      end
      KIND_RELEASE: begin
        if (size == 0) begin
          g.status = ST_ZERO;
        end else if (addr >= FAE_MEM_SIZE) begin
          g.status = ST_NOFIT;
        end else if (free_cnt >= FAE_MAX_EXTENTS) begin
          g.status = ST_FULL;
        end else begin
          last = addr + size - 1;
          if (last > FAE_MEM_SIZE - 1) last = FAE_MEM_SIZE - 1;
          pos = 0;
          while (pos < free_cnt && int'(free_lo[pos]) < addr) pos++;
          for (i = free_cnt; i > pos; i--) begin
            free_lo[i] = free_lo[i - 1];
            free_hi[i] = free_hi[i - 1];
          end
          free_lo[pos] = ADDR_W'(addr);
          free_hi[pos] = ADDR_W'(last);
          free_cnt++;
          g.granted = 1'b1;
        end
      end
      KIND_COMPACT: begin
        // merge only exact neighbors; the end of memory never wraps onto address 0
        i = 1;
        while (i < free_cnt) begin
          if (int'(free_hi[i - 1]) + 1 == int'(free_lo[i])) begin
            free_hi[i - 1] = free_hi[i];
            drop_extent(i);
          end else begin
            i++;
          end
        end
        g.granted = 1'b1;
      end
      default: ;
    endcase
    return g;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(input logic [KIND_W-1:0] kind, input int size, input int addr,
                              input bit typed, input grant_t want, output grant_t got);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {{PAD_W{1'b0}}, ADDR_W'(addr), SIZE_W'(size)};
    do @(posedge clk); while (!s_tready);
    got = predict_grant(kind, size, addr);
    pending_grants.push_back(typed ? want : got);
  endtask

  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_grants.size() != 0);
  endtask

  // toggles stretches where neither side idles
  initial begin
    forever begin
      repeat ($urandom_range(50, 300)) @(posedge clk);
      calm <= ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    int     stall;
    grant_t want;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (pending_grants.size() == 0) begin
          $error("result with no request pending: m_tdata %h", m_tdata);
          mismatches++;
        end else begin
          want = pending_grants.pop_front();
          if (m_tdata[0] !== want.granted) begin
            $error("granted: expected %0d, got %0d", want.granted, m_tdata[0]);
            mismatches++;
          end
          if (m_tdata[10:1] !== want.alloc_addr) begin
            $error("alloc_addr: expected %0d, got %0d", want.alloc_addr, m_tdata[10:1]);
            mismatches++;
          end
          if (m_tdata[12:11] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tdata[12:11]);
            mismatches++;
          end
        end
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        stall = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
    end
  end

  initial begin
    grant_t got;
    block_t blk;
    int     pick;
    int     r;
    int     sz;
    int     compact_pct;
    compact_pct = 10;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[n]) begin
      for (int k = 0; k < directed_plan[n].reps; k++) begin
        send_request(directed_plan[n].kind, directed_plan[n].size,
                     directed_plan[n].addr + k * directed_plan[n].step,
                     directed_plan[n].typed, directed_plan[n].want, got);
      end
    end

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      // phases with rare compaction let the table fragment until it fills
      if (n % 100 == 0) compact_pct = $urandom_range(0, 1) ? 2 : 20;
      if (n % 170 == 169) wait_all_results();
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_request(KIND_UNUSED, $urandom_range(0, 1024), $urandom_range(0, 1023),
                     1'b0, '0, got);
      end else if (r < 3 + compact_pct) begin
        send_request(KIND_COMPACT, $urandom_range(0, 1024), $urandom_range(0, 1023),
                     1'b0, '0, got);
      end else if (r < 55) begin
        r = $urandom_range(0, 99);
        if (r < 3) sz = 0;
        else if (r < 80) sz = $urandom_range(1, 48);
        else if (r < 95) sz = $urandom_range(49, 400);
        else sz = $urandom_range(401, 1024);
        send_request(KIND_ALLOC, sz, $urandom_range(0, 1023), 1'b0, '0, got);
        if (got.granted) begin
          blk.addr = got.alloc_addr;
          blk.size = sz;
          held_blocks.push_back(blk);
        end
      end else if (r < 88 && held_blocks.size() > 0) begin
        pick = $urandom_range(0, held_blocks.size() - 1);
        blk  = held_blocks[pick];
        held_blocks.delete(pick);
        send_request(KIND_RELEASE, blk.size, blk.addr, 1'b0, '0, got);
      end else begin
        // stray release: random range, may overlap anything
        send_request(KIND_RELEASE, $urandom_range(0, 1024), $urandom_range(0, 1023),
                     1'b0, '0, got);
      end
    end

    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/fae_pkg.sv
sv/first_fit_extent_allocator.sv
sv/fae_checker.sv
tb/testbench.sv
